/* rtl/sha256_stream_hasher_macros.svh */
// Assertion macros shared by the SHA-256 stream hasher RTL.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define S256_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha256_stream_hasher: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define S256_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha256_stream_hasher: next-cycle check failed");

`else

`define S256_ASSERT(label, ante, cons)
`define S256_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/s256_pkg.sv */
// Package for the SHA-256 stream hasher: types, constants, round tables and
// the sigma functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s256_pkg;

  localparam int COUNT_W = 61;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [2:0] LAST_WORD   = 3'd7;

  typedef logic [7:0][31:0]  s256_words8_t;
  typedef logic [15:0][31:0] s256_window_t;

  localparam s256_words8_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD1,
    ST_PAD2,
    ST_COMP,
    ST_OUT
  } s256_state_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD
  } s256_core_state_t;

  // Control from the sequencer to the compression core, valid for one cycle.
  typedef struct packed {
    logic        init;
    logic        start;
    logic        wr_byte;
    logic        pad;
    logic        pad_mark;
    logic        pad_len;
    logic [5:0]  pos;
    logic [7:0]  data;
    logic [63:0] bit_len;
    logic [2:0]  rd_index;
  } s256_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } s256_status_t;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

/* rtl/s256_round.sv */
// One SHA-256 round on the eight working words; the shared unit of the core.
// Depends on s256_pkg for the word type and the sigma functions.
`timescale 1ns / 1ps
`default_nettype none

module s256_round
  import s256_pkg::*;
(
  input  wire s256_words8_t vars_in,
  input  wire logic [31:0]  wt,
  input  wire logic [31:0]  kt,
  output s256_words8_t      vars_out
);

  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  always_comb begin
    ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
    maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2]) ^
          (vars_in[1] & vars_in[2]);
    t1  = vars_in[7] + bsig1(vars_in[4]) + ch + kt + wt;
    t2  = bsig0(vars_in[0]) + maj;

    vars_out[0] = t1 + t2;
    vars_out[1] = vars_in[0];
    vars_out[2] = vars_in[1];
    vars_out[3] = vars_in[2];
    vars_out[4] = vars_in[3] + t1;
    vars_out[5] = vars_in[4];
    vars_out[6] = vars_in[5];
    vars_out[7] = vars_in[6];
  end

endmodule

`default_nettype wire

/* rtl/s256_core.sv */
// SHA-256 compression core: block window, schedule, working words, hash state
// and the round sequencer. Depends on s256_pkg and s256_round.
`timescale 1ns / 1ps
`default_nettype none

module s256_core
  import s256_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire s256_cmd_t   cmd,
  output s256_status_t     status,
  output logic [31:0]      rd_word
);

  s256_core_state_t core_state;
  s256_core_state_t core_state_next;
  logic [5:0]       round;
  s256_words8_t     vars;
  s256_words8_t     vars_round;
  s256_words8_t     hash;
  s256_window_t     window;
  logic [31:0]      w_new;
  logic [7:0]       len_bytes [8];
  logic [4:0]       lane_lo;

  s256_round u_round (
    .vars_in  (vars),
    .wt       (window[0]),
    .kt       (ROUND_K[round]),
    .vars_out (vars_round)
  );

  always_comb begin
    core_state_next = core_state;
    case (core_state)
      CORE_IDLE:  if (cmd.start) core_state_next = CORE_ROUND;
      CORE_ROUND: if (round == LAST_ROUND) core_state_next = CORE_ADD;
      CORE_ADD:   core_state_next = CORE_IDLE;
      default:    core_state_next = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      core_state <= CORE_IDLE;
    end else begin
      core_state <= core_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || core_state != CORE_ROUND) begin
      round <= '0;
    end else begin
      round <= round + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      hash <= INIT_HASH;
    end else if (core_state == CORE_ADD) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + vars[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (core_state == CORE_IDLE && cmd.start) begin
      vars <= hash;
    end else if (core_state == CORE_ROUND) begin
      vars <= vars_round;
    end
  end

  // The window slides by one word per round; the word entering at the top is
  // the next schedule word, so word 0 always holds the current round's input.
  assign w_new   = ssig1(window[14]) + window[9] + ssig0(window[1]) + window[0];
  assign lane_lo = {~cmd.pos[1:0], 3'b000};

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      len_bytes[k] = cmd.bit_len[8*k +: 8];
    end
  end

  // Byte j of the block sits in word j/4, most significant byte first.
  always_ff @(posedge clk) begin
    if (core_state == CORE_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        window[i] <= window[i+1];
      end
      window[15] <= w_new;
    end else if (cmd.pad) begin
      for (int j = 0; j < 64; j++) begin
        if (6'(j) < cmd.pos) begin
          window[j/4][31-8*(j%4) -: 8] <= window[j/4][31-8*(j%4) -: 8];
        end else if (cmd.pad_mark && 6'(j) == cmd.pos) begin
          window[j/4][31-8*(j%4) -: 8] <= PAD_BYTE;
        end else if (cmd.pad_len && 6'(j) >= LEN_POS) begin
          window[j/4][31-8*(j%4) -: 8] <= len_bytes[3'(63-j)];
        end else begin
          window[j/4][31-8*(j%4) -: 8] <= 8'h00;
        end
      end
    end else if (cmd.wr_byte) begin
      window[cmd.pos[5:2]][lane_lo +: 8] <= cmd.data;
    end
  end

  assign status.busy = (core_state != CORE_IDLE);
  assign status.done = (core_state == CORE_ADD);
  assign rd_word     = hash[cmd.rd_index];

endmodule

`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// SHA-256 stream hasher. Each input transfer with s_tuser[0] set takes one
// message byte; the transfer that completes a 64-byte block is followed by
// compression (64 rounds through the single round unit, then the add into
// the hash state), during which s_tready is low. The transfer with tlast
// set adds padding and one compression (two when the message length
// modulo 64 is 56 or more), after which the eight digest words leave on the
// master side, H0 first, and the block returns to the initial hash state.
// Depends on s256_pkg, s256_core and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_stream_hasher_macros.svh"

module sha256_stream_hasher
  import s256_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  input  wire  [0:0]  s_tuser,   // [0] byte_valid
  input  wire         s_tlast,   // last_item
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // last_word
);

  s256_state_t        state;
  s256_state_t        state_next;
  s256_state_t        resume;
  s256_state_t        resume_next;
  logic [COUNT_W-1:0] count;
  logic [2:0]         out_idx;
  s256_cmd_t          cmd;
  s256_status_t       core_st;
  logic [31:0]        rd_word;
  logic               in_xfer;
  logic               out_xfer;

  s256_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (core_st),
    .rd_word (rd_word)
  );

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  always_comb begin
    state_next   = state;
    resume_next  = resume;
    cmd          = '0;
    cmd.pos      = count[5:0];
    cmd.data     = s_tdata;
    cmd.bit_len  = {count, 3'b000};
    cmd.rd_index = out_idx;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.wr_byte = s_tuser[0];
          if (s_tuser[0] && count[5:0] == LAST_POS) begin
            cmd.start   = 1'b1;
            state_next  = ST_COMP;
            resume_next = s_tlast ? ST_PAD1 : ST_IDLE;
          end else if (s_tlast) begin
            state_next = ST_PAD1;
          end
        end
      end
      ST_PAD1: begin
        // The length fits behind the pad byte only below byte 56.
        cmd.pad      = 1'b1;
        cmd.pad_mark = 1'b1;
        cmd.pad_len  = (count[5:0] < LEN_POS);
        cmd.start    = 1'b1;
        state_next   = ST_COMP;
        resume_next  = (count[5:0] < LEN_POS) ? ST_OUT : ST_PAD2;
      end
      ST_PAD2: begin
        cmd.pad     = 1'b1;
        cmd.pad_len = 1'b1;
        cmd.pos     = '0;
        cmd.start   = 1'b1;
        state_next  = ST_COMP;
        resume_next = ST_OUT;
      end
      ST_COMP: begin
        if (core_st.done) state_next = resume;
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready && out_idx == LAST_WORD) begin
          cmd.init   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      resume <= ST_IDLE;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (out_xfer && out_idx == LAST_WORD)) begin
      count <= '0;
    end else if (in_xfer && s_tuser[0]) begin
      count <= count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_idx <= '0;
    end else if (out_xfer) begin
      out_idx <= out_idx + 3'd1;
    end
  end

  assign m_tdata = rd_word;
  assign m_tuser = out_idx;
  assign m_tlast = (out_idx == LAST_WORD);

  `S256_ASSERT(a_out_excludes_in, m_tvalid, !s_tready)
  `S256_ASSERT_NEXT(a_idle_after_digest, out_xfer && m_tlast, !m_tvalid && s_tready && (count == '0))
  `S256_ASSERT(a_start_core_idle, cmd.start, !core_st.busy)
  `S256_ASSERT(a_digest_after_compress, $rose(m_tvalid), $past(core_st.done))

endmodule

`default_nettype wire
